FILE: rtl/weighted_gaussian_filter_macros.svh
// Assertion helpers, clocked on i_clk, held off during reset.
`ifndef WEIGHTED_GAUSSIAN_FILTER_MACROS_SVH
`define WEIGHTED_GAUSSIAN_FILTER_MACROS_SVH

`define WGF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wgf assertion failed");

`define WGF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wgf assertion failed");

`endif

FILE: rtl/wgf_pkg.sv
`timescale 1ns / 1ps
package wgf_pkg;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS = 7;
    localparam int DEF_PIXEL_BITS = 16;
    localparam int OUT_BITS       = 24;
    localparam int CFG_BITS       = 9;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [1:0] {
        FN_PIXEL  = 2'd0,
        FN_WEIGHT = 2'd1,
        FN_CALC   = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BIG  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_RROWS  = 3'd2,
        CFG_RCOLS  = 3'd3,
        CFG_BORDER = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BM_ZERO    = 2'd0,
        BM_NEAREST = 2'd1,
        BM_CIRC    = 2'd2,
        BM_MIRROR  = 2'd3
    } t_border;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SUM,
        S_CNT,
        S_SEL,
        S_DIV,
        S_OUT
    } t_state;
endpackage

FILE: rtl/wgf_ram.sv
`timescale 1ns / 1ps
module wgf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/wgf_div.sv
`timescale 1ns / 1ps
module wgf_div #(
    parameter int NW = 48,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CB = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CB-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_num[NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CB'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
            r_num <= {r_num[NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

FILE: rtl/weighted_gaussian_filter.sv
// Channel   Direction  Signals                                   Moves
// request   in         i_valid/o_ready, func,row,col,data_value  writes and compute requests
// result    out        o_valid/i_ready, out_value,status         one per in-frame compute
// config    in         i_cfg_we, i_cfg_index, i_cfg_data         register writes, no wait
// A compute whose window fits the frame runs three passes over the window
// through one frame read port, then, if the weight sum is nonzero, a 48-step
// restoring divide. Synchronous active-low reset; stores are not cleared.
// A waiting result holds the block in its last state until taken.
`timescale 1ns / 1ps
`include "weighted_gaussian_filter_macros.svh"
module weighted_gaussian_filter
    import wgf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_func,
    input  logic [7:0]              i_row,
    input  logic [7:0]              i_col,
    input  logic [15:0]             i_data_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [OUT_BITS-1:0]     o_out_value,
    output logic [1:0]              o_status,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);
    localparam int KSIDE = 2 * MAX_RADIUS + 1;
    localparam int NTAP  = KSIDE * KSIDE;
    localparam int TB    = $clog2(KSIDE);
    localparam int KA    = $clog2(NTAP);
    localparam int NB    = $clog2(NTAP + 1);
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CW    = ($clog2(MAXD) + 2 > 10) ? $clog2(MAXD) + 2 : 10;
    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int FA    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int SUMW  = 16 + NB;
    localparam int PSW   = 32 + NB;
    localparam int NUMW  = PSW + 8;

    t_state r_state, n_state;

    logic [CFG_BITS-1:0] r_cfg_w, r_cfg_h;
    logic [2:0]          r_cfg_ry, r_cfg_rx;
    logic [1:0]          r_cfg_bm;

    logic [7:0]    r_row, r_col;
    logic [TB-1:0] r_ti, r_tj;
    logic          r_issue, r_p1, r_z1, r_p2;
    logic [NB-1:0] r_n, r_cnt;
    logic          r_take;
    logic [SUMW-1:0] r_sum, r_wsum, r_vn2;
    logic [15:0]     r_w2;
    logic [31:0]     r_vw2;
    logic [PSW-1:0]  r_psum;
    logic [OUT_BITS-1:0] r_res_val, r_out_val;
    t_status         r_res_st, r_out_st;
    logic            r_ovalid;

    logic [CW-1:0] w_eff, h_eff;
    logic [3:0]    ry, rx;
    logic          accept, last_tap, pass_done, in_pass, ge2, out_free;
    logic signed [CW-1:0] py, px;
    logic [CW:0]   ymap, xmap;
    logic [FA-1:0] f_raddr, f_waddr;
    logic [KA-1:0] k_raddr, k_waddr;
    logic          f_we, k_we;
    logic [PIXEL_BITS-1:0] f_rdata;
    logic [15:0]   k_rdata, v1;
    logic          div_done;
    logic [NUMW-1:0] div_quot;

    function automatic logic [CW-1:0] clamp_size(input logic [CFG_BITS-1:0] v,
                                                 input logic [CW-1:0] mx);
        logic [CW-1:0] e;
        e = CW'(v);
        if (e == '0) begin
            return CW'(1);
        end else if (e > mx) begin
            return mx;
        end
        return e;
    endfunction

    // returns {in_frame, index}
    function automatic logic [CW:0] map_coord(input logic signed [CW-1:0] p,
                                              input logic [CW-1:0] n,
                                              input logic [1:0] bm);
        logic signed [CW-1:0] sn;
        logic                 neg, over;
        sn   = $signed(n);
        neg  = p[CW-1];
        over = !neg && (p >= sn);
        if (!neg && !over) begin
            return {1'b1, p};
        end
        unique case (t_border'(bm))
            BM_ZERO:    return {1'b0, CW'(0)};
            BM_NEAREST: return {1'b1, neg ? CW'(0) : CW'(n - 1'b1)};
            BM_CIRC:    return {1'b1, neg ? CW'(p + sn) : CW'(p - sn)};
            BM_MIRROR:  return {1'b1, neg ? CW'(~p) : CW'({n, 1'b0} - 1'b1 - p)};
            default:    return {1'b0, CW'(0)};
        endcase
    endfunction

    assign w_eff = clamp_size(r_cfg_w, CW'(MAX_WIDTH));
    assign h_eff = clamp_size(r_cfg_h, CW'(MAX_HEIGHT));
    assign ry = ({1'b0, r_cfg_ry} > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : {1'b0, r_cfg_ry};
    assign rx = ({1'b0, r_cfg_rx} > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : {1'b0, r_cfg_rx};

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign in_pass = (r_state == S_SUM) || (r_state == S_CNT) || (r_state == S_SEL);
    assign last_tap = (r_ti == TB'({ry, 1'b0})) && (r_tj == TB'({rx, 1'b0}));
    assign pass_done = in_pass && !r_issue && !r_p1 && !r_p2;
    assign out_free  = !r_ovalid || i_ready;

    assign py = $signed(CW'(r_row) - CW'(ry) + CW'(r_ti));
    assign px = $signed(CW'(r_col) - CW'(rx) + CW'(r_tj));
    assign ymap = map_coord(py, h_eff, r_cfg_bm);
    assign xmap = map_coord(px, w_eff, r_cfg_bm);

    assign f_raddr = FA'(ymap[YB-1:0]) * FA'(MAX_WIDTH) + FA'(xmap[XB-1:0]);
    assign k_raddr = KA'(r_ti) * KA'(KSIDE) + KA'(r_tj);
    assign f_we    = accept && (t_func'(i_func) == FN_PIXEL)
                     && (CW'(i_row) < CW'(MAX_HEIGHT)) && (CW'(i_col) < CW'(MAX_WIDTH));
    assign k_we    = accept && (t_func'(i_func) == FN_WEIGHT)
                     && ({1'b0, i_row} < 9'(KSIDE)) && ({1'b0, i_col} < 9'(KSIDE));
    assign f_waddr = FA'(i_row[YB-1:0]) * FA'(MAX_WIDTH) + FA'(i_col[XB-1:0]);
    assign k_waddr = KA'(i_row[TB-1:0]) * KA'(KSIDE) + KA'(i_col[TB-1:0]);

    wgf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_frame (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (i_data_value[PIXEL_BITS-1:0]),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    wgf_ram #(.WIDTH(16), .DEPTH(NTAP)) u_kernel (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (i_data_value),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    wgf_div #(.NW(NUMW), .DW(SUMW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_SEL) && pass_done && (r_wsum != '0)),
        .i_num   ({r_psum, 8'd0} + NUMW'(r_wsum[SUMW-1:1])),
        .i_den   (r_wsum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign v1  = r_z1 ? 16'd0 : 16'(f_rdata);
    assign ge2 = r_vn2 >= r_sum;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && t_func'(i_func) == FN_CALC) n_state = S_CHECK;
            S_CHECK: begin
                if (CW'(r_row) >= h_eff || CW'(r_col) >= w_eff) begin
                    n_state = S_IDLE;
                end else if (CW'({ry, 1'b1}) > h_eff || CW'({rx, 1'b1}) > w_eff) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_SUM:   if (pass_done) n_state = S_CNT;
            S_CNT:   if (pass_done) n_state = S_SEL;
            S_SEL:   if (pass_done) n_state = (r_wsum == '0) ? S_OUT : S_DIV;
            S_DIV:   if (div_done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= CFG_BITS'(256);
            r_cfg_h  <= CFG_BITS'(256);
            r_cfg_ry <= 3'd1;
            r_cfg_rx <= 3'd1;
            r_cfg_bm <= BM_ZERO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_w  <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h  <= i_cfg_data;
                CFG_RROWS:  r_cfg_ry <= i_cfg_data[2:0];
                CFG_RCOLS:  r_cfg_rx <= i_cfg_data[2:0];
                CFG_BORDER: r_cfg_bm <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
        end else begin
            r_p1 <= r_issue;
            r_p2 <= r_p1;
            if (r_state == S_CHECK || (pass_done && r_state != S_SEL)) begin
                r_issue <= (n_state == S_SUM) || (n_state == S_CNT) || (n_state == S_SEL);
            end else if (r_issue && last_tap) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if (r_state == S_CHECK || pass_done) begin
            r_ti <= '0;
            r_tj <= '0;
        end else if (r_issue) begin
            if (r_tj == TB'({rx, 1'b0})) begin
                r_tj <= '0;
                r_ti <= r_ti + 1'b1;
            end else begin
                r_tj <= r_tj + 1'b1;
            end
        end
        r_z1  <= !(ymap[CW] && xmap[CW]);
        r_vn2 <= SUMW'(v1) * SUMW'(r_n);
        r_vw2 <= 32'(v1) * 32'(k_rdata);
        r_w2  <= k_rdata;
        if (r_state == S_CHECK) begin
            r_n      <= NB'(NB'({ry, 1'b1}) * NB'({rx, 1'b1}));
            r_sum    <= '0;
            r_cnt    <= '0;
            r_wsum   <= '0;
            r_psum   <= '0;
            r_res_val <= '0;
            r_res_st  <= ST_BIG;
        end
        if (r_p1 && r_state == S_SUM) begin
            r_sum <= r_sum + SUMW'(v1);
        end
        if (r_p2 && r_state == S_CNT && ge2) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == S_CNT && pass_done) begin
            r_take <= {r_cnt, 1'b0} >= {1'b0, r_n};
        end
        if (r_p2 && r_state == S_SEL && ge2 == r_take) begin
            r_wsum <= r_wsum + SUMW'(r_w2);
            r_psum <= r_psum + PSW'(r_vw2);
        end
        if (r_state == S_SEL && pass_done && r_wsum == '0) begin
            r_res_val <= '0;
            r_res_st  <= ST_ZERO;
        end
        if (div_done) begin
            r_res_val <= div_quot[OUT_BITS-1:0];
            r_res_st  <= ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_val <= r_res_val;
            r_out_st  <= r_res_st;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_value = r_out_val;
    assign o_status    = r_out_st;

    `WGF_ASSERT_IMP(a_busy_not_ready, r_state != S_IDLE, !o_ready)
    `WGF_ASSERT_IMP(a_div_in_div, div_done, r_state == S_DIV)
    `WGF_ASSERT_IMP(a_pipe_in_pass, r_p2, in_pass)
    `WGF_ASSERT_NEXT(a_zero_status, r_state == S_OUT && out_free && r_res_st != ST_OK,
                     o_valid && o_out_value == '0)
endmodule
